>>> sv/fpwt_pkg.sv
// fpwt_pkg: shared constants, codes and types of the flow pulse window totaliser
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package fpwt_pkg;

  // default parameter values
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TOTAL_WIDTH_DEF = 32;

  // fixed field widths
  localparam int CMD_W   = 2;
  localparam int OUT_W   = 48;
  localparam int CAL_W   = 8;
  localparam int OFS_W   = 16;
  localparam int START_W = 32;
  localparam int MS_W    = 10;
  localparam int TIMER_W = 11;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // reset values of the configuration registers
  localparam logic [CAL_W-1:0]   CAL_RST   = 8'd1;
  localparam logic [OFS_W-1:0]   OFS_RST   = 16'd1;
  localparam logic [START_W-1:0] START_RST = 32'd0;
  localparam logic [MS_W-1:0]    DMIN_RST  = 10'd50;
  localparam logic [MS_W-1:0]    SLOT_RST  = 10'd50;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_PUBLISH = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CAL   = 3'd0,
    REG_OFS   = 3'd1,
    REG_START = 3'd2,
    REG_DMIN  = 3'd3,
    REG_SLOT  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLOW,
    S_TOTAL,
    S_MFLOW,
    S_MTOTAL,
    S_HOLD
  } state_t;

endpackage

`default_nettype wire

>>> sv/fpwt_in_if.sv
// fpwt_in_if: input channel, valid/ready with command and pin sample
// depends on fpwt_pkg
`default_nettype none

interface fpwt_in_if;
  logic                      valid;
  logic                      ready;
  logic [fpwt_pkg::CMD_W-1:0] cmd;
  logic                      pin_level;

  modport source (output valid, cmd, pin_level, input ready);
  modport sink   (input valid, cmd, pin_level, output ready);
endinterface

`default_nettype wire

>>> sv/fpwt_out_if.sv
// fpwt_out_if: result channel, valid/ready with scaled flow and total
// depends on fpwt_pkg
`default_nettype none

interface fpwt_out_if;
  logic                      valid;
  logic                      ready;
  logic [fpwt_pkg::OUT_W-1:0] flow_scaled;
  logic [fpwt_pkg::OUT_W-1:0] total_scaled;
  logic                      total_saturated;

  modport source (output valid, flow_scaled, total_scaled, total_saturated, input ready);
  modport sink   (input valid, flow_scaled, total_scaled, total_saturated, output ready);
endinterface

`default_nettype wire

>>> sv/fpwt_serial_mul.sv
// fpwt_serial_mul: shift-add multiplier, one multiplier bit per cycle, msb first
// no dependencies
`default_nettype none

module fpwt_serial_mul #(
  parameter int AW = 40,
  parameter int BW = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start_i,
  input  wire logic [AW-1:0]   a_i,
  input  wire logic [BW-1:0]   b_i,
  output      logic            busy_o,
  output      logic            done_o,
  output      logic [AW+BW-1:0] prod_o
);

  localparam int CNTW = $clog2(BW + 1);
  localparam logic [CNTW-1:0] BW_CNT = CNTW'(BW);

  logic [CNTW-1:0]  cnt_r,  cnt_nxt;
  logic             done_r, done_nxt;
  logic [AW-1:0]    a_r,    a_nxt;
  logic [BW-1:0]    b_r,    b_nxt;
  logic [AW+BW-1:0] acc_r,  acc_nxt;

  always_comb begin
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (start_i) begin
      cnt_nxt = BW_CNT;
      a_nxt   = a_i;
      b_nxt   = b_i;
      acc_nxt = '0;
    end else if (cnt_r != '0) begin
      // double and add the multiplicand where the current bit is set
      acc_nxt  = {acc_r[AW+BW-2:0], 1'b0} + (b_r[BW-1] ? (AW+BW)'(a_r) : '0);
      b_nxt    = {b_r[BW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign busy_o = (cnt_r != '0);
  assign done_o = done_r;
  assign prod_o = acc_r;

endmodule

`default_nettype wire

>>> sv/flow_pulse_window_totalizer_unit.sv
// flow_pulse_window_totalizer_unit: top level of the flow pulse window totaliser
// depends on fpwt_pkg, fpwt_in_if, fpwt_out_if and fpwt_serial_mul
//
// channel  direction  transfer contents
// in_ch    sink       cmd (tick / publish / clear), pin_level
// out_ch   source     flow_scaled, total_scaled, total_saturated (publish only)
// apb      slave      five registers at byte address 4*index, write and read
//
// tick and clear items are taken in idle and done at once
// a publish makes three passes of the serial multiplier (16 bits
//   of multiplier per pass), one total update and one load
// the result sits in an output register; ticks and clears keep flowing while it waits,
//   only the load of the next publish result waits for the previous transfer
// rst_n is synchronous, active low; it restores registers and pulse state
`default_nettype none

module flow_pulse_window_totalizer_unit #(
  parameter int COUNT_WIDTH = fpwt_pkg::COUNT_WIDTH_DEF,
  parameter int TOTAL_WIDTH = fpwt_pkg::TOTAL_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  fpwt_in_if.sink                              in_ch,
  fpwt_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fpwt_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fpwt_pkg::APB_DATA_W-1:0] pwdata,
  output      logic [fpwt_pkg::APB_DATA_W-1:0] prdata,
  output      logic                            pready
);

  localparam int CAL_W   = fpwt_pkg::CAL_W;
  localparam int OFS_W   = fpwt_pkg::OFS_W;
  localparam int START_W = fpwt_pkg::START_W;
  localparam int MS_W    = fpwt_pkg::MS_W;
  localparam int TIMER_W = fpwt_pkg::TIMER_W;
  localparam int OUT_W   = fpwt_pkg::OUT_W;
  localparam int DATA_W  = fpwt_pkg::APB_DATA_W;
  localparam int ADDR_W  = fpwt_pkg::APB_ADDR_W;

  // flow width, shared multiplicand width, product width, floor compare width
  localparam int FW = COUNT_WIDTH + CAL_W;
  localparam int MA = (TOTAL_WIDTH > FW) ? TOTAL_WIDTH : FW;
  localparam int PW = MA + OFS_W;
  localparam int LW = (TOTAL_WIDTH > START_W) ? TOTAL_WIDTH : START_W;

  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TIMER_W-1:0]     TIMER_MAX = '1;
  localparam logic [PW-1:0]          OUT_LIM   = PW'({OUT_W{1'b1}});

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CAL_W-1:0]   cfg_cal_r;
  logic [OFS_W-1:0]   cfg_ofs_r;
  logic [START_W-1:0] cfg_start_r;
  logic [MS_W-1:0]    cfg_dmin_r;
  logic [MS_W-1:0]    cfg_slot_r;

  fpwt_pkg::reg_idx_t cfg_idx;
  logic               cfg_wr;

  assign cfg_idx = fpwt_pkg::reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cal_r   <= fpwt_pkg::CAL_RST;
      cfg_ofs_r   <= fpwt_pkg::OFS_RST;
      cfg_start_r <= fpwt_pkg::START_RST;
      cfg_dmin_r  <= fpwt_pkg::DMIN_RST;
      cfg_slot_r  <= fpwt_pkg::SLOT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fpwt_pkg::REG_CAL:   cfg_cal_r   <= pwdata[CAL_W-1:0];
        fpwt_pkg::REG_OFS:   cfg_ofs_r   <= pwdata[OFS_W-1:0];
        fpwt_pkg::REG_START: cfg_start_r <= pwdata[START_W-1:0];
        fpwt_pkg::REG_DMIN:  cfg_dmin_r  <= pwdata[MS_W-1:0];
        fpwt_pkg::REG_SLOT:  cfg_slot_r  <= pwdata[MS_W-1:0];
        default: ;  // addresses past the register list are ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fpwt_pkg::REG_CAL:   prdata = DATA_W'(cfg_cal_r);
      fpwt_pkg::REG_OFS:   prdata = DATA_W'(cfg_ofs_r);
      fpwt_pkg::REG_START: prdata = DATA_W'(cfg_start_r);
      fpwt_pkg::REG_DMIN:  prdata = DATA_W'(cfg_dmin_r);
      fpwt_pkg::REG_SLOT:  prdata = DATA_W'(cfg_slot_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  fpwt_pkg::state_t         state_r,   state_nxt;
  logic                     last_pin_r, last_pin_nxt;
  logic                     armed_r,   armed_nxt;
  logic [TIMER_W-1:0]       timer_r,   timer_nxt;
  logic [COUNT_WIDTH-1:0]   count_r,   count_nxt;
  logic [TOTAL_WIDTH-1:0]   total_r,   total_nxt;
  logic [FW-1:0]            flow_r,    flow_nxt;
  logic [OUT_W-1:0]         flow_sc_r, flow_sc_nxt;
  logic [OUT_W-1:0]         tot_sc_r,  tot_sc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]         out_flow_r, out_flow_nxt;
  logic [OUT_W-1:0]         out_tot_r,  out_tot_nxt;
  logic                     out_sat_r,  out_sat_nxt;

  logic                     in_xfer;

  assign in_ch.ready = (state_r == fpwt_pkg::S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------------
  // tick: low-time timer and pulse qualification, all narrow
  // ---------------------------------------------------------------------------
  logic [TIMER_W-1:0]     upper;
  logic [TIMER_W-1:0]     dmin_ext;
  logic [TIMER_W-1:0]     tick_t1;
  logic                   tick_armed;
  logic [TIMER_W-1:0]     tick_timer;
  logic [COUNT_WIDTH-1:0] tick_count;

  assign dmin_ext = TIMER_W'(cfg_dmin_r);
  assign upper    = dmin_ext + TIMER_W'(cfg_slot_r);

  always_comb begin
    tick_t1    = timer_r;
    tick_armed = armed_r;
    tick_timer = timer_r;
    tick_count = count_r;
    if (armed_r) begin
      // timer holds at its top value
      if (timer_r != TIMER_MAX) begin
        tick_t1 = timer_r + 1'b1;
      end
      tick_timer = tick_t1;
      if (in_ch.pin_level || (tick_t1 > upper)) begin
        // pulse decided: inside the window counts, anything else breaks the run
        if ((tick_t1 >= dmin_ext) && (tick_t1 <= upper)) begin
          if (count_r != COUNT_MAX) begin
            tick_count = count_r + 1'b1;
          end
        end else begin
          tick_count = '0;
        end
        tick_armed = 1'b0;
        tick_timer = '0;
      end
    end
    // falling edge arms a new low-time measurement
    if (!tick_armed && last_pin_r && !in_ch.pin_level) begin
      tick_armed = 1'b1;
      tick_timer = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // publish: floor and saturating add of the total
  // ---------------------------------------------------------------------------
  logic [LW-1:0]          start_ext;
  logic [LW-1:0]          floor_ext;
  logic [TOTAL_WIDTH-1:0] floor_v;
  logic [TOTAL_WIDTH-1:0] base_v;
  logic [MA:0]            sum_v;
  logic [TOTAL_WIDTH-1:0] new_total;

  assign start_ext = LW'(cfg_start_r);
  assign floor_ext = (start_ext > LW'(TOTAL_MAX)) ? LW'(TOTAL_MAX) : start_ext;
  assign floor_v   = floor_ext[TOTAL_WIDTH-1:0];
  assign base_v    = (total_r < floor_v) ? floor_v : total_r;
  assign sum_v     = (MA+1)'(base_v) + (MA+1)'(flow_r);
  assign new_total = (sum_v > (MA+1)'(TOTAL_MAX)) ? TOTAL_MAX : sum_v[TOTAL_WIDTH-1:0];

  // ---------------------------------------------------------------------------
  // shared serial multiplier: count*cal, flow*ofs, total*ofs in turn
  // ---------------------------------------------------------------------------
  logic             mul_start;
  logic [MA-1:0]    mul_a;
  logic [OFS_W-1:0] mul_b;
  logic             mul_busy;
  logic             mul_done;
  logic [PW-1:0]    mul_prod;
  logic [OUT_W-1:0] mul_sat;

  fpwt_serial_mul #(
    .AW (MA),
    .BW (OFS_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // reported values clip at the 48-bit output range
  assign mul_sat = (mul_prod > OUT_LIM) ? {OUT_W{1'b1}} : OUT_W'(mul_prod);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    last_pin_nxt  = last_pin_r;
    armed_nxt     = armed_r;
    timer_nxt     = timer_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    flow_nxt      = flow_r;
    flow_sc_nxt   = flow_sc_r;
    tot_sc_nxt    = tot_sc_r;
    out_flow_nxt  = out_flow_r;
    out_tot_nxt   = out_tot_r;
    out_sat_nxt   = out_sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      fpwt_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.cmd)
            fpwt_pkg::CMD_TICK: begin
              armed_nxt    = tick_armed;
              timer_nxt    = tick_timer;
              count_nxt    = tick_count;
              last_pin_nxt = in_ch.pin_level;
            end
            fpwt_pkg::CMD_PUBLISH: begin
              // count is captured by the multiplier and cleared; a pulse in progress stays armed
              mul_start = 1'b1;
              mul_a     = MA'(count_r);
              mul_b     = OFS_W'(cfg_cal_r);
              count_nxt = '0;
              state_nxt = fpwt_pkg::S_FLOW;
            end
            fpwt_pkg::CMD_CLEAR: begin
              total_nxt = '0;
              count_nxt = '0;
              armed_nxt = 1'b0;
              timer_nxt = '0;
            end
            default: ;  // unused command, no effect
          endcase
        end
      end

      fpwt_pkg::S_FLOW: begin
        if (mul_done) begin
          flow_nxt  = mul_prod[FW-1:0];
          state_nxt = fpwt_pkg::S_TOTAL;
        end
      end

      fpwt_pkg::S_TOTAL: begin
        total_nxt = new_total;
        mul_start = 1'b1;
        mul_a     = MA'(flow_r);
        mul_b     = cfg_ofs_r;
        state_nxt = fpwt_pkg::S_MFLOW;
      end

      fpwt_pkg::S_MFLOW: begin
        if (mul_done) begin
          flow_sc_nxt = mul_sat;
          mul_start   = 1'b1;
          mul_a       = MA'(total_r);
          mul_b       = cfg_ofs_r;
          state_nxt   = fpwt_pkg::S_MTOTAL;
        end
      end

      fpwt_pkg::S_MTOTAL: begin
        if (mul_done) begin
          tot_sc_nxt = mul_sat;
          state_nxt  = fpwt_pkg::S_HOLD;
        end
      end

      fpwt_pkg::S_HOLD: begin
        // load once the output register is free or being emptied this cycle
        if (!out_valid_r || out_ch.ready) begin
          out_flow_nxt  = flow_sc_r;
          out_tot_nxt   = tot_sc_r;
          out_sat_nxt   = (total_r == TOTAL_MAX);
          out_valid_nxt = 1'b1;
          state_nxt     = fpwt_pkg::S_IDLE;
        end
      end

      default: state_nxt = fpwt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpwt_pkg::S_IDLE;
      last_pin_r  <= 1'b1;
      armed_r     <= 1'b0;
      timer_r     <= '0;
      count_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_pin_r  <= last_pin_nxt;
      armed_r     <= armed_nxt;
      timer_r     <= timer_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flow_r     <= flow_nxt;
    flow_sc_r  <= flow_sc_nxt;
    tot_sc_r   <= tot_sc_nxt;
    out_flow_r <= out_flow_nxt;
    out_tot_r  <= out_tot_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.flow_scaled     = out_flow_r;
  assign out_ch.total_scaled    = out_tot_r;
  assign out_ch.total_saturated = out_sat_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  a_publish_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == fpwt_pkg::CMD_PUBLISH) |=>
      (state_r == fpwt_pkg::S_FLOW && count_r == '0))
    else $error("publish did not start the flow multiply");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == fpwt_pkg::CMD_CLEAR) |=>
      (count_r == '0 && total_r == '0 && !armed_r))
    else $error("clear left state behind");

  a_tick_total: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.cmd == fpwt_pkg::CMD_TICK) |=> $stable(total_r))
    else $error("tick changed the total");

  a_out_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fpwt_pkg::S_HOLD))
    else $error("result raised outside the load state");

endmodule

`default_nettype wire
